### rtl/gcl_pkg.sv
package gcl_pkg;

  localparam int unsigned PID_W    = 12;
  localparam int unsigned DIM_W    = 5;
  localparam int unsigned GDIM     = 32;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned CAP      = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned MAXN     = 64;
  localparam int unsigned K_W      = 7;
  localparam int unsigned CELL_W   = 2 * DIM_W;
  localparam int unsigned CELLS    = GDIM * GDIM;
  localparam int unsigned MEM_AW   = CELL_W + SLOT_W;
  localparam int unsigned MEM_D    = CELLS * CAP;
  localparam int unsigned NPART    = 4096;
  localparam int unsigned P_W      = 1 + 2 * DIM_W + SLOT_W;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [PID_W-1:0] pid;
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic             on_grid;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
  } dims_t;

  typedef struct packed {
    logic [PID_W-1:0]  neighbor_id;
    logic              has_neighbor;
    logic              is_last;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  cell_count;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  max_cell_count;
  } res_t;

endpackage

### rtl/gcl_if.sv
interface gcl_in_if;
  import gcl_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [PID_W-1:0] particle_id;
  logic [DIM_W-1:0] cell_x;
  logic [DIM_W-1:0] cell_y;
  modport source (output valid, op, particle_id, cell_x, cell_y, input ready);
  modport sink (input valid, op, particle_id, cell_x, cell_y, output ready);
endinterface

interface gcl_out_if;
  import gcl_pkg::*;
  logic              valid;
  logic              ready;
  logic [PID_W-1:0]  neighbor_id;
  logic              has_neighbor;
  logic              is_last;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  cell_count;
  logic [SLOT_W-1:0] slot_index;
  logic [CNT_W-1:0]  max_cell_count;
  modport source (output valid, neighbor_id, has_neighbor, is_last, status, cell_count,
                  slot_index, max_cell_count, input ready);
  modport sink (input valid, neighbor_id, has_neighbor, is_last, status, cell_count,
                slot_index, max_cell_count, output ready);
endinterface

interface gcl_cfg_if;
  import gcl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/gcl_ram.sv
module gcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/gcl_front.sv
module gcl_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  gcl_in_if.sink        in_i,
  input  gcl_pkg::dims_t dims_i,
  input  logic          pop_i,
  output gcl_pkg::head_t head_o
);
  import gcl_pkg::*;

  item_t      fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      it;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready && (in_i.op <= OP_CLEAR);

  always_comb begin
    it.op      = in_i.op;
    it.pid     = in_i.particle_id;
    it.x       = in_i.cell_x;
    it.y       = in_i.cell_y;
    it.on_grid = ({1'b0, in_i.cell_x} < dims_i.w) && ({1'b0, in_i.cell_y} < dims_i.h);
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end
endmodule

### rtl/gcl_back.sv
module gcl_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gcl_pkg::head_t head_i,
  input  gcl_pkg::dims_t dims_i,
  output logic           pop_o,
  gcl_out_if.source      out_o
);
  import gcl_pkg::*;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_PRD    = 5'd2;
  localparam logic [4:0] S_TFILL  = 5'd3;
  localparam logic [4:0] S_UFILL  = 5'd4;
  localparam logic [4:0] S_UMEM   = 5'd5;
  localparam logic [4:0] S_UWR    = 5'd6;
  localparam logic [4:0] S_PLACE  = 5'd7;
  localparam logic [4:0] S_REPORT = 5'd8;
  localparam logic [4:0] S_RES    = 5'd9;
  localparam logic [4:0] S_QOWN   = 5'd10;
  localparam logic [4:0] S_QCELL  = 5'd11;
  localparam logic [4:0] S_QFILL  = 5'd12;
  localparam logic [4:0] S_QSLOT  = 5'd13;
  localparam logic [4:0] S_QMEM   = 5'd14;
  localparam logic [4:0] S_QPUSH  = 5'd15;
  localparam logic [4:0] S_QEND   = 5'd16;

  logic [4:0]        state_q;
  item_t             it_q;
  logic [PID_W-1:0]  clr_cnt_q;
  logic              clr_emit_q;
  logic [DIM_W-1:0]  pcol_q, prow_q;
  logic [SLOT_W-1:0] pslot_q;
  logic [CNT_W-1:0]  tn_q, last_q, own_q, qn_q, qi_q;
  logic [CNT_W-1:0]  peak_q;
  logic [STAT_W-1:0] rep_stat_q, res_stat_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [1:0]        dxi_q, dyi_q;
  logic [CELL_W-1:0] qc_q;
  logic [K_W-1:0]    k_q;
  logic              more_q, hold_v_q;
  logic [PID_W-1:0]  hold_id_q, qid_q;
  logic              out_vld_q;
  res_t              out_q;
  logic              out_free;

  logic              p_we, f_we, m_we;
  logic [PID_W-1:0]  p_waddr, p_raddr;
  logic [P_W-1:0]    p_wdata, p_rdata;
  logic [CELL_W-1:0] f_waddr, f_raddr;
  logic [CNT_W-1:0]  f_wdata, f_rdata;
  logic [MEM_AW-1:0] m_waddr, m_raddr;
  logic [PID_W-1:0]  m_wdata, m_rdata;

  logic              rd_placed;
  logic [DIM_W-1:0]  rd_col, rd_row;
  logic [SLOT_W-1:0] rd_slot;
  logic [CELL_W-1:0] old_c, new_c, qcell;
  logic [DIM_W+1:0]  nx, ny;
  logic              qon;
  logic [CNT_W-1:0]  ulast;

  assign rd_placed = p_rdata[P_W-1];
  assign rd_col    = p_rdata[P_W-2 -: DIM_W];
  assign rd_row    = p_rdata[SLOT_W + DIM_W - 1 -: DIM_W];
  assign rd_slot   = p_rdata[SLOT_W-1:0];
  assign old_c     = {prow_q, pcol_q};
  assign new_c     = {it_q.y, it_q.x};
  assign ulast     = f_rdata - CNT_W'(1);

  assign nx    = {2'b00, pcol_q} + {{DIM_W{1'b0}}, dxi_q} - (DIM_W+2)'(1);
  assign ny    = {2'b00, prow_q} + {{DIM_W{1'b0}}, dyi_q} - (DIM_W+2)'(1);
  assign qon   = !nx[DIM_W+1] && !ny[DIM_W+1] && (nx[DIM_W:0] < dims_i.w) &&
                 (ny[DIM_W:0] < dims_i.h);
  assign qcell = {ny[DIM_W-1:0], nx[DIM_W-1:0]};

  assign out_free = !out_vld_q || out_o.ready;
  assign pop_o    = (state_q == S_IDLE) && head_i.valid;

  gcl_ram #(.WIDTH(P_W), .DEPTH(NPART)) u_part (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  gcl_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_fill (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  gcl_ram #(.WIDTH(PID_W), .DEPTH(MEM_D)) u_memb (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  always_comb begin
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
    case (state_q)
      S_CLR: begin
        p_we    = 1'b1;
        p_waddr = clr_cnt_q;
        f_we    = 1'b1;
        f_waddr = clr_cnt_q[CELL_W-1:0];
      end
      S_IDLE: p_raddr = head_i.item.pid;
      S_PRD: begin
        if ((it_q.op == OP_INSERT && rd_placed) || it_q.op == OP_REMOVE ||
            it_q.op == OP_QUERY) begin
          f_raddr = {rd_row, rd_col};
        end else begin
          f_raddr = new_c;
        end
      end
      S_TFILL: f_raddr = old_c;
      S_UFILL: m_raddr = {old_c, ulast[SLOT_W-1:0]};
      S_UMEM: begin
        m_we    = 1'b1;
        m_waddr = {old_c, pslot_q};
        m_wdata = m_rdata;
        p_we    = 1'b1;
        p_waddr = m_rdata;
        p_wdata = {1'b1, pcol_q, prow_q, pslot_q};
      end
      S_UWR: begin
        f_we    = 1'b1;
        f_waddr = old_c;
        f_wdata = last_q;
        if (it_q.op == OP_REMOVE) begin
          p_we    = 1'b1;
          p_waddr = it_q.pid;
        end
      end
      S_PLACE: begin
        m_we    = 1'b1;
        m_waddr = {new_c, tn_q[SLOT_W-1:0]};
        m_wdata = it_q.pid;
        f_we    = 1'b1;
        f_waddr = new_c;
        f_wdata = tn_q + CNT_W'(1);
        p_we    = 1'b1;
        p_waddr = it_q.pid;
        p_wdata = {1'b1, it_q.x, it_q.y, tn_q[SLOT_W-1:0]};
      end
      S_QCELL: f_raddr = qcell;
      S_QSLOT: m_raddr = {qc_q, qi_q[SLOT_W-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: it_q <= head_i.item;
      S_PRD: begin
        pcol_q  <= rd_col;
        prow_q  <= rd_row;
        pslot_q <= rd_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_cnt_q  <= '0;
      clr_emit_q <= 1'b0;
      peak_q     <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
      hold_v_q   <= 1'b0;
      hold_id_q  <= '0;
      qid_q      <= '0;
      more_q     <= 1'b0;
      k_q        <= '0;
      dxi_q      <= '0;
      dyi_q      <= '0;
      qc_q       <= '0;
      qn_q       <= '0;
      qi_q       <= '0;
      own_q      <= '0;
      tn_q       <= '0;
      last_q     <= '0;
      rep_stat_q <= STAT_OK;
      res_stat_q <= STAT_OK;
      res_cnt_q  <= '0;
      res_slot_q <= '0;
    end else begin
      if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + PID_W'(1);
          if (&clr_cnt_q) begin
            clr_emit_q <= 1'b0;
            res_stat_q <= STAT_OK;
            res_cnt_q  <= '0;
            res_slot_q <= '0;
            state_q    <= clr_emit_q ? S_RES : S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_i.valid) begin
            state_q <= S_PRD;
          end
        end
        S_PRD: begin
          res_stat_q <= STAT_BAD;
          res_cnt_q  <= '0;
          res_slot_q <= '0;
          case (it_q.op)
            OP_CLEAR: begin
              clr_cnt_q  <= '0;
              clr_emit_q <= 1'b1;
              state_q    <= S_CLR;
            end
            OP_INSERT: begin
              if (rd_placed) begin
                rep_stat_q <= STAT_BAD;
                state_q    <= S_REPORT;
              end else if (!it_q.on_grid) begin
                state_q <= S_RES;
              end else begin
                state_q <= S_TFILL;
              end
            end
            OP_MOVE: begin
              if (!rd_placed || !it_q.on_grid) begin
                state_q <= S_RES;
              end else if (rd_col == it_q.x && rd_row == it_q.y) begin
                rep_stat_q <= STAT_OK;
                state_q    <= S_REPORT;
              end else begin
                state_q <= S_TFILL;
              end
            end
            OP_REMOVE: state_q <= rd_placed ? S_UFILL : S_RES;
            OP_QUERY:  state_q <= rd_placed ? S_QOWN : S_RES;
            default:   state_q <= S_IDLE;
          endcase
        end
        S_TFILL: begin
          tn_q <= f_rdata;
          if (f_rdata >= CNT_W'(CAP)) begin
            res_stat_q <= STAT_FULL;
            res_cnt_q  <= f_rdata;
            res_slot_q <= '0;
            state_q    <= S_RES;
          end else begin
            state_q <= (it_q.op == OP_MOVE) ? S_UFILL : S_PLACE;
          end
        end
        S_UFILL: begin
          last_q  <= ulast;
          state_q <= ({1'b0, pslot_q} != ulast) ? S_UMEM : S_UWR;
        end
        S_UMEM: state_q <= S_UWR;
        S_UWR: begin
          if (it_q.op == OP_REMOVE) begin
            res_stat_q <= STAT_OK;
            res_cnt_q  <= last_q;
            res_slot_q <= '0;
            state_q    <= S_RES;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (tn_q + CNT_W'(1) > peak_q) begin
            peak_q <= tn_q + CNT_W'(1);
          end
          res_stat_q <= STAT_OK;
          res_cnt_q  <= tn_q + CNT_W'(1);
          res_slot_q <= tn_q[SLOT_W-1:0];
          state_q    <= S_RES;
        end
        S_REPORT: begin
          res_stat_q <= rep_stat_q;
          res_cnt_q  <= f_rdata;
          res_slot_q <= pslot_q;
          state_q    <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_q     <= '{neighbor_id: '0, has_neighbor: 1'b0, is_last: 1'b1,
                           status: res_stat_q, cell_count: res_cnt_q,
                           slot_index: res_slot_q, max_cell_count: peak_q};
            state_q   <= S_IDLE;
          end
        end
        S_QOWN: begin
          own_q    <= f_rdata;
          dxi_q    <= '0;
          dyi_q    <= '0;
          k_q      <= '0;
          more_q   <= 1'b0;
          hold_v_q <= 1'b0;
          state_q  <= S_QCELL;
        end
        S_QCELL: begin
          if (dyi_q == 2'd3) begin
            state_q <= S_QEND;
          end else begin
            qc_q <= qcell;
            if (dxi_q == 2'd2) begin
              dxi_q <= '0;
              dyi_q <= dyi_q + 2'd1;
            end else begin
              dxi_q <= dxi_q + 2'd1;
            end
            if (qon) begin
              state_q <= S_QFILL;
            end
          end
        end
        S_QFILL: begin
          qn_q    <= f_rdata;
          qi_q    <= '0;
          state_q <= S_QSLOT;
        end
        S_QSLOT: begin
          if (qi_q == qn_q) begin
            state_q <= S_QCELL;
          end else if (k_q == K_W'(MAXN)) begin
            more_q  <= 1'b1;
            state_q <= S_QEND;
          end else begin
            state_q <= S_QMEM;
          end
        end
        S_QMEM: begin
          qid_q   <= m_rdata;
          state_q <= S_QPUSH;
        end
        S_QPUSH: begin
          if (!hold_v_q || out_free) begin
            if (hold_v_q) begin
              out_vld_q <= 1'b1;
              out_q     <= '{neighbor_id: hold_id_q, has_neighbor: 1'b1, is_last: 1'b0,
                             status: STAT_OK, cell_count: own_q,
                             slot_index: pslot_q, max_cell_count: peak_q};
            end
            hold_id_q <= qid_q;
            hold_v_q  <= 1'b1;
            k_q       <= k_q + K_W'(1);
            qi_q      <= qi_q + CNT_W'(1);
            state_q   <= S_QSLOT;
          end
        end
        S_QEND: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_q     <= '{neighbor_id: hold_v_q ? hold_id_q : '0,
                           has_neighbor: hold_v_q, is_last: 1'b1,
                           status: (hold_v_q && more_q) ? STAT_TRUNC : STAT_OK,
                           cell_count: own_q, slot_index: pslot_q,
                           max_cell_count: peak_q};
            hold_v_q  <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.neighbor_id    = out_q.neighbor_id;
  assign out_o.has_neighbor   = out_q.has_neighbor;
  assign out_o.is_last        = out_q.is_last;
  assign out_o.status         = out_q.status;
  assign out_o.cell_count     = out_q.cell_count;
  assign out_o.slot_index     = out_q.slot_index;
  assign out_o.max_cell_count = out_q.max_cell_count;
endmodule

### rtl/grid_cell_list_neighbor_engine.sv
// Insert, remove and move items each give one result; one item is worked on at a time.
// A query reads neighbour slots through the single read port of the cell member memory.
// A clear item sweeps the fill and particle memories and gives its one result.
// After reset the same sweep runs before the first item is started; the two-entry
// input queue and configuration writes are taken during it.
module grid_cell_list_neighbor_engine (
  input logic clk_i,
  input logic rst_ni,
  gcl_in_if.sink     in_i,
  gcl_out_if.source  out_o,
  gcl_cfg_if.sink    cfg_i
);
  import gcl_pkg::*;

  logic [CFG_W-1:0] grid_w_q, grid_h_q;
  dims_t            dims;
  head_t            head;
  logic             pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= CFG_W'(GDIM);
      grid_h_q <= CFG_W'(GDIM);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_GRID_WIDTH:  grid_w_q <= cfg_i.data;
        CFG_GRID_HEIGHT: grid_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign dims.w = (grid_w_q > CFG_W'(GDIM)) ? CFG_W'(GDIM) : grid_w_q;
  assign dims.h = (grid_h_q > CFG_W'(GDIM)) ? CFG_W'(GDIM) : grid_h_q;

  gcl_front u_front (
    .clk_i, .rst_ni, .in_i, .dims_i(dims), .pop_i(pop), .head_o(head)
  );

  gcl_back u_back (
    .clk_i, .rst_ni, .head_i(head), .dims_i(dims), .pop_o(pop), .out_o
  );

  a_found_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.has_neighbor |-> out_o.status == STAT_OK ||
                                          out_o.status == STAT_TRUNC)
    else $error("found id with bad status");

  a_empty_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.has_neighbor |-> out_o.is_last && out_o.neighbor_id == '0)
    else $error("empty result not last");

  a_trunc_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == STAT_TRUNC |-> out_o.is_last && out_o.has_neighbor)
    else $error("truncation not on last id");

  a_peak_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.max_cell_count <= CNT_W'(CAP) &&
                    out_o.cell_count <= out_o.max_cell_count)
    else $error("count above peak");
endmodule
